/* hw/rtl/mpz_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mpz_pkg;

  // Port widths fixed by the interface.
  localparam int SAMPLE_PORT_W = 64;
  localparam int ROW_WIDTH_W   = 13;
  localparam int MODE_W        = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MODE = 1'b1;

  // Active sample width in bits, 1..64.
  localparam int BITS_W = 7;
  typedef logic [BITS_W-1:0] bits_t;

  // Which neighbors lie inside the image.
  typedef struct packed {
    logic use_w;
    logic use_n;
    logic use_nw;
  } nbr_sel_t;

endpackage

`default_nettype wire

/* hw/rtl/mpz_med_zigzag.sv */
`timescale 1ns / 1ps
`default_nettype none

// MED prediction, residual and zigzag map at the active width.
module mpz_med_zigzag import mpz_pkg::*; #(
  parameter int SW = 64
) (
  input  wire logic [SW-1:0] x,
  input  wire logic [SW-1:0] west,
  input  wire logic [SW-1:0] north,
  input  wire logic [SW-1:0] northwest,
  input  wire nbr_sel_t      sel,
  input  wire bits_t         bits,
  output logic [SW-1:0]      code
);

  logic [SW-1:0] mask;
  logic [SW-1:0] top_bit;
  logic [SW-1:0] xv, wv, nv, nwv;
  logic [SW-1:0] lo, hi, pred, resid;
  logic          sign;

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      mask[i]    = (BITS_W'(i) < bits);
      top_bit[i] = (BITS_W'(i + 1) == bits);
    end
  end

  assign xv  = x & mask;
  assign wv  = sel.use_w  ? (west & mask)      : '0;
  assign nv  = sel.use_n  ? (north & mask)     : '0;
  assign nwv = sel.use_nw ? (northwest & mask) : '0;

  assign lo = (wv < nv) ? wv : nv;
  assign hi = (wv < nv) ? nv : wv;

  always_comb begin
    priority if (nwv >= hi) begin
      pred = lo;
    end else if (nwv <= lo) begin
      pred = hi;
    end else begin
      pred = (wv + nv - nwv) & mask;
    end
  end

  assign resid = (xv - pred) & mask;
  assign sign  = |(resid & top_bit);
  assign code  = ((resid << 1) ^ {SW{sign}}) & mask;

endmodule

`default_nettype wire

/* hw/rtl/med_predict_zigzag_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: the line store read and the stage 1 registers load at the input accept edge;
// the result register, which drives out_valid, loads when stage 1 advances.
// Throughput: one item per cycle with out_ready high; one line store read and write per accept.
// Reset: synchronous, active-low rst_n; clears pipeline valids, column, first-row flag,
// neighbor registers and config (row_width=1, sample_width_mode=0). The line store is
// not cleared; the first image row reads its entries but does not use them.
module med_predict_zigzag_encoder import mpz_pkg::*; #(
  parameter int MAX_ROW_WIDTH   = 4096,
  parameter int MAX_SAMPLE_BITS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // config write port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
  // input samples
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [SAMPLE_PORT_W-1:0] in_sample_value,
  input  wire logic                     in_last_of_image,
  // coded residuals
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [SAMPLE_PORT_W-1:0]      out_zigzag_code
);

  localparam int SW   = MAX_SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_ROW_WIDTH);
  // compare width: holds column+1, the row width register and the max row width
  localparam int CMPW = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [MODE_W-1:0]      mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_W'(1);
      mode_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:   row_width_r <= cfg_wdata[ROW_WIDTH_W-1:0];
        REG_SAMPLE_MODE: mode_r      <= cfg_wdata[MODE_W-1:0];
      endcase
    end
  end

  // Active width: 8 << mode, limited to the storage width.
  bits_t bits_raw;
  bits_t bits;
  assign bits_raw = BITS_W'(8) << mode_r;
  assign bits     = (bits_raw > BITS_W'(SW)) ? BITS_W'(SW) : bits_raw;

  // Effective row width: zero reads as one, large values saturate.
  logic [CMPW-1:0] rw_ext;
  logic [CMPW-1:0] eff_w;
  assign rw_ext = CMPW'(row_width_r);

  always_comb begin
    priority if (rw_ext == '0) begin
      eff_w = CMPW'(1);
    end else if (rw_ext > CMPW'(MAX_ROW_WIDTH)) begin
      eff_w = CMPW'(MAX_ROW_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_fire;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  // ---------------------------------------------------------------------------
  // Raster position
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   col_r, col_nxt;
  logic            pfr_r, pfr_nxt;   // past the first row of the image
  logic [CMPW-1:0] col_inc;
  logic            row_end;

  assign col_inc = CMPW'(col_r) + CMPW'(1);
  assign row_end = (col_inc >= eff_w);

  // last sample wins over the end of a row
  always_comb begin
    priority if (in_last_of_image) begin
      col_nxt = '0;
      pfr_nxt = 1'b0;
    end else if (row_end) begin
      col_nxt = '0;
      pfr_nxt = 1'b1;
    end else begin
      col_nxt = col_inc[CW-1:0];
      pfr_nxt = pfr_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: read-before-write at the accept edge, so the item sees the
  // sample above it and leaves its own for the next row.
  // ---------------------------------------------------------------------------
  logic [SW-1:0] line_mem [MAX_ROW_WIDTH];
  logic [SW-1:0] above_r;
  logic [SW-1:0] x_in;
  logic [SW-1:0] wmask;       // ones below the active width

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      wmask[i] = (BITS_W'(i) < bits);
    end
  end

  // samples are stored cut to the width they were coded at
  assign x_in = in_sample_value[SW-1:0] & wmask;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_mem[col_r] <= x_in;
      above_r         <= line_mem[col_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers and neighbors
  // ---------------------------------------------------------------------------
  logic [SW-1:0] west_r;      // last accepted sample
  logic [SW-1:0] nw_r;        // above sample of the last item that left stage 1
  logic [SW-1:0] s1_x_r;
  logic [SW-1:0] s1_w_r;
  nbr_sel_t      s1_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      pfr_r       <= 1'b0;
      west_r      <= '0;
      nw_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        col_r  <= col_nxt;
        pfr_r  <= pfr_nxt;
        west_r <= x_in;
      end
      if (s1_adv) begin
        nw_r <= above_r & wmask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r          <= x_in;
      s1_w_r          <= west_r;
      s1_sel_r.use_w  <= (col_r != '0);
      s1_sel_r.use_n  <= pfr_r;
      s1_sel_r.use_nw <= pfr_r && (col_r != '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Predict and code, then the result register
  // ---------------------------------------------------------------------------
  logic [SW-1:0]            code;
  logic [SAMPLE_PORT_W-1:0] out_code_r;

  mpz_med_zigzag #(
    .SW (SW)
  ) u_med (
    .x         (s1_x_r),
    .west      (s1_w_r),
    .north     (above_r),
    .northwest (nw_r),
    .sel       (s1_sel_r),
    .bits      (bits),
    .code      (code)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_code_r <= SAMPLE_PORT_W'(code);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_zigzag_code = out_code_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(col_r) < CMPW'(MAX_ROW_WIDTH))
    else $error("column position beyond line store");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_of_image |=> (col_r == '0) && !pfr_r)
    else $error("last sample did not restart the raster");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_last_of_image && row_end |=> (col_r == '0) && pfr_r)
    else $error("row end did not wrap to the next row");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_x_r) && $stable(above_r))
    else $error("stalled stage 1 item lost");

  a_code_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_code_r >> bits) == '0))
    else $error("code has bits above the active width");

endmodule

`default_nettype wire
